>>> rtl/core/iiea_pkg.sv
// shared types, operation codes and status codes for the insert/erase array
package iiea_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KIND_W    = 4;
    localparam int IDX_W     = 5;
    localparam int WORD_W    = 32;
    localparam int STAT_W    = 2;

    localparam logic [KIND_W-1:0] K_READ   = 4'd0;
    localparam logic [KIND_W-1:0] K_WRITE  = 4'd1;
    localparam logic [KIND_W-1:0] K_INSERT = 4'd2;
    localparam logic [KIND_W-1:0] K_ERASE  = 4'd3;
    localparam logic [KIND_W-1:0] K_PUSH   = 4'd4;
    localparam logic [KIND_W-1:0] K_POP    = 4'd5;
    localparam logic [KIND_W-1:0] K_CLEAR  = 4'd6;
    localparam logic [KIND_W-1:0] K_RESIZE = 4'd7;
    localparam logic [KIND_W-1:0] K_ASSIGN = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        t_word             item_value;
        logic [IDX_W-1:0]  new_count;
    } t_in;

    typedef struct packed {
        t_word             read_value;
        logic [IDX_W-1:0]  length;
        t_word             front_value;
        t_word             back_value;
        logic [STAT_W-1:0] status;
    } t_out;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic  wr;
        logic  ins;
        logic  ers;
        logic  push;
        logic  rsz;
        logic  asg;
        t_word value;
    } t_cell_ctl;

endpackage

>>> rtl/core/iiea_cell.sv
// one storage cell of the list: loads, shifts from a neighbor, and drives its output taps
module iiea_cell import iiea_pkg::*; #(
    parameter int CW  = 5,
    parameter int POS = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [IDX_W-1:0] i_cnt,
    input  logic [CW-1:0]    i_live,
    input  t_word            i_left,
    input  t_word            i_right,
    input  logic             i_tap_rd,
    input  logic [IDX_W-1:0] i_tap_idx,
    output t_word            o_word,
    output t_word            o_rd_tap,
    output t_word            o_front_tap,
    output t_word            o_back_tap
);

    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CMPW-1:0] P  = CMPW'(POS);
    localparam logic [CMPW-1:0] P1 = CMPW'(POS + 1);

    t_word           r_word;
    t_word           n_word;
    logic [CMPW-1:0] w_x;
    logic [CMPW-1:0] w_c;
    logic [CMPW-1:0] w_n;
    logic [CMPW-1:0] w_tx;

    assign w_x  = CMPW'(i_idx);
    assign w_c  = CMPW'(i_live);
    assign w_n  = CMPW'(i_cnt);
    assign w_tx = CMPW'(i_tap_idx);

    always_comb begin
        n_word = r_word;
        if (i_ctl.wr && (P == w_x)) begin
            n_word = i_ctl.value;
        end
        if (i_ctl.ins) begin
            if (P == w_x) begin
                n_word = i_ctl.value;
            end else if ((P > w_x) && (P <= w_c)) begin
                n_word = i_left;
            end
        end
        if (i_ctl.ers && (P >= w_x) && (P1 < w_c)) begin
            n_word = i_right;
        end
        if (i_ctl.push && (P == w_c)) begin
            n_word = i_ctl.value;
        end
        if (i_ctl.rsz && (P >= w_c) && (P < w_n)) begin
            n_word = i_ctl.value;
        end
        if (i_ctl.asg && (P < w_n)) begin
            n_word = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word      = r_word;
    assign o_rd_tap    = (i_tap_rd && (P == w_tx)) ? r_word : '0;
    assign o_front_tap = ((POS == 0) && (w_c != '0)) ? r_word : '0;
    assign o_back_tap  = (P1 == w_c) ? r_word : '0;

endmodule

>>> rtl/core/iiea_cmd.sv
// operation decode: range and capacity checks, status, next length, cell broadcast
module iiea_cmd import iiea_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = 5
) (
    input  logic              i_fire,
    input  t_in               i_cmd,
    input  logic [CW-1:0]     i_live,
    output t_cell_ctl         o_ctl,
    output logic [STAT_W-1:0] o_status,
    output logic [CW-1:0]     o_live_nxt,
    output logic              o_rd_ok
);

    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CMPW-1:0] DMAX = CMPW'(DEPTH);

    logic [CMPW-1:0] w_x;
    logic [CMPW-1:0] w_c;
    logic [CMPW-1:0] w_n;
    logic            w_past_end;
    logic            w_ins_range;
    logic            w_full;
    logic            w_cnt_big;

    assign w_x         = CMPW'(i_cmd.index);
    assign w_c         = CMPW'(i_live);
    assign w_n         = CMPW'(i_cmd.new_count);
    assign w_past_end  = (w_x >= w_c);
    assign w_ins_range = (w_x > w_c);
    assign w_full      = (w_c >= DMAX);
    assign w_cnt_big   = (w_n > DMAX);

    always_comb begin
        o_ctl       = '0;
        o_ctl.value = i_cmd.item_value;
        o_status    = ST_OK;
        o_live_nxt  = i_live;
        o_rd_ok     = 1'b0;
        case (i_cmd.kind)
            K_READ: begin
                if (w_past_end) begin
                    o_status = ST_RANGE;
                end else begin
                    o_rd_ok = 1'b1;
                end
            end
            K_WRITE: begin
                if (w_past_end) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.wr = i_fire;
                end
            end
            K_INSERT: begin
                if (w_ins_range) begin
                    o_status = ST_RANGE;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.ins  = i_fire;
                    o_live_nxt = CW'(i_live + CW'(1));
                end
            end
            K_ERASE: begin
                if (w_past_end) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.ers  = i_fire;
                    o_live_nxt = CW'(i_live - CW'(1));
                end
            end
            K_PUSH: begin
                if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.push = i_fire;
                    o_live_nxt = CW'(i_live + CW'(1));
                end
            end
            K_POP: begin
                if (w_c == '0) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_live_nxt = CW'(i_live - CW'(1));
                end
            end
            K_CLEAR: begin
                o_live_nxt = '0;
            end
            K_RESIZE: begin
                if (w_cnt_big) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.rsz  = i_fire;
                    o_live_nxt = CW'(w_n);
                end
            end
            K_ASSIGN: begin
                if (w_cnt_big) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.asg  = i_fire;
                    o_live_nxt = CW'(w_n);
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

>>> rtl/core/indexed_insert_erase_array.sv
// top level: list of shift cells with length register, result collect stage and output register
//
//   beat      | valid        | ready        | payload
//   ----------+--------------+--------------+------------------
//   command   | i_in_valid   | o_in_ready   | i_in_data  (t_in)
//   result    | o_out_valid  | i_out_ready  | o_out_data (t_out)
//
// a command updates the cells and the length at its accept edge; the collect stage,
// once the output register is free, gathers read, front and back words from the cell
// taps into the output register. one command per cycle when results are taken as fast
// as they come. a stalled result blocks the collect stage and, through it, o_in_ready.
// reset clears the length and both valid flags; cell contents are left as they are.
module indexed_insert_erase_array import iiea_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_live;
    logic [CW-1:0]     n_live;
    logic              r_pend;
    logic              r_rd_ok;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [STAT_W-1:0] r_status;
    logic              r_out_vld;
    t_out              r_out;

    logic              w_accept;
    logic              w_collect;
    logic              w_out_free;
    t_cell_ctl         w_ctl;
    logic [STAT_W-1:0] w_status;
    logic              w_rd_ok;

    t_word             w_word      [DEPTH];
    t_word             w_rd_tap    [DEPTH];
    t_word             w_front_tap [DEPTH];
    t_word             w_back_tap  [DEPTH];
    t_word             w_rd_or;
    t_word             w_front_or;
    t_word             w_back_or;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_collect  = r_pend && w_out_free;
    assign o_in_ready = !r_pend || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    iiea_cmd #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_cmd (
        .i_fire     (w_accept),
        .i_cmd      (i_in_data),
        .i_live     (r_live),
        .o_ctl      (w_ctl),
        .o_status   (w_status),
        .o_live_nxt (n_live),
        .o_rd_ok    (w_rd_ok)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        iiea_cell #(
            .CW  (CW),
            .POS (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_idx       (i_in_data.index),
            .i_cnt       (i_in_data.new_count),
            .i_live      (r_live),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_tap_rd    (r_rd_ok),
            .i_tap_idx   (r_rd_idx),
            .o_word      (w_word[g]),
            .o_rd_tap    (w_rd_tap[g]),
            .o_front_tap (w_front_tap[g]),
            .o_back_tap  (w_back_tap[g])
        );
    end

    // at most one cell drives each tap, so a plain or merges them
    always_comb begin
        w_rd_or    = '0;
        w_front_or = '0;
        w_back_or  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_or    = w_rd_or | w_rd_tap[k];
            w_front_or = w_front_or | w_front_tap[k];
            w_back_or  = w_back_or | w_back_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_live <= n_live;
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_collect) begin
                r_pend <= 1'b0;
            end
            if (w_collect) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_ok  <= w_rd_ok;
            r_rd_idx <= i_in_data.index;
            r_status <= w_status;
        end
        if (w_collect) begin
            r_out.read_value  <= w_rd_or;
            r_out.length      <= IDX_W'(r_live);
            r_out.front_value <= w_front_or;
            r_out.back_value  <= w_back_or;
            r_out.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/iiea_chk.sv
// port-level checker for the insert/erase array and its bind
module iiea_chk import iiea_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    localparam int LW = IDX_W + 1;

    // a result never reports more live entries than there are cells
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (LW'(o_out_data.length) <= LW'(DEPTH)))
        else $error("length above depth");

    // an empty list shows zero at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.length == '0))
        |-> ((o_out_data.front_value == '0) && (o_out_data.back_value == '0)))
        else $error("nonzero front or back on empty list");

    // an empty status only comes from a pop that found nothing
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_EMPTY)) |-> (o_out_data.length == '0))
        else $error("empty status with live entries");

    // a fresh result follows an accepted command at an earlier cycle
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without command");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat dropped or changed while stalled");

endmodule

bind indexed_insert_erase_array iiea_chk #(
    .DEPTH (DEPTH)
) u_iiea_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
